FILE: rtl/image_convolution_filter_defines.svh
// Assertion macros used by the checker of this block.
`ifndef IMAGE_CONVOLUTION_FILTER_DEFINES_SVH
`define IMAGE_CONVOLUTION_FILTER_DEFINES_SVH

// Property checked outside reset.
`define ICF_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every edge, reset included.
`define ICF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/icf_pkg.sv
package icf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_KERNEL = 8;

  localparam int PIX_W   = 8;
  localparam int PIX_MAX = 255;
  localparam int SOBEL_K = 3;

  localparam int OCOL_W = 10;
  localparam int OROW_W = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_WID_W  = 11;
  localparam int CFG_HGT_W  = 12;
  localparam int CFG_BOX_W  = 4;

  localparam logic [CFG_WID_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_HGT_W-1:0] RST_HEIGHT = 12'd480;
  localparam logic                 RST_MODE   = 1'b0;
  localparam logic [CFG_BOX_W-1:0] RST_BOX    = 4'd3;

  localparam logic MODE_SOBEL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_FILTER_MODE  = 3'd2,
    CFG_BOX_SIZE     = 3'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM1,
    ST_SUM2,
    ST_DIV,
    ST_FIN
  } icf_state_t;

  typedef struct packed {
    logic wr;
    logic shift;
    logic sum1;
    logic sum2;
    logic step;
  } lane_ctrl_t;

endpackage

FILE: rtl/icf_div.sv
module icf_div #(
  parameter int SUM_W = 14,
  parameter int DIV_W = 7
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [SUM_W-1:0] quotient
);
  import icf_pkg::*;

  logic [SUM_W-1:0] q_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W:0]   sh;

  // restoring division, one quotient bit per step, MSB first
  assign sh = {rem_r, q_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (load) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (step) begin
      if (sh >= {1'b0, divisor}) begin
        rem_r <= DIV_W'(sh - {1'b0, divisor});
        q_r   <= {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= sh[DIV_W-1:0];
        q_r   <= {q_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = q_r;

endmodule

FILE: rtl/icf_lane.sv
module icf_lane #(
  parameter int MAX_WIDTH  = icf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = icf_pkg::DEF_MAX_KERNEL,
  localparam int COL_W  = $clog2(MAX_WIDTH),
  localparam int BANK_W = $clog2(MAX_KERNEL),
  localparam int KW     = $clog2(MAX_KERNEL + 1),
  localparam int DIV_W  = $clog2(MAX_KERNEL * MAX_KERNEL + 1)
) (
  input  logic                     clk,
  input  icf_pkg::lane_ctrl_t      ctrl,
  input  logic [COL_W-1:0]         addr,
  input  logic [BANK_W-1:0]        wr_bank,
  input  logic [BANK_W-1:0]        rd_bank,
  input  logic [icf_pkg::PIX_W-1:0] pix,
  input  logic                     mode,
  input  logic [KW-1:0]            k,
  input  logic [DIV_W-1:0]         divisor,
  output logic [icf_pkg::PIX_W-1:0] result
);
  import icf_pkg::*;

  localparam int ROW_W = $clog2(MAX_KERNEL * PIX_MAX + 1);
  localparam int SUM_W = $clog2(MAX_KERNEL * MAX_KERNEL * PIX_MAX + 1);

  logic [MAX_KERNEL-1:0][PIX_W-1:0] rd;
  logic [PIX_W-1:0] pix_r;
  logic [PIX_W-1:0] colv [MAX_KERNEL];
  logic [PIX_W-1:0] win_r [MAX_KERNEL][MAX_KERNEL];
  logic [ROW_W-1:0] rowsum_nxt [MAX_KERNEL];
  logic [ROW_W-1:0] rowsum_r [MAX_KERNEL];
  logic [SUM_W-1:0] total_nxt;
  logic [SUM_W-1:0] quotient;
  logic signed [PIX_W+2:0] acc;
  logic [PIX_W-1:0] sobel_nxt;
  logic [PIX_W-1:0] sobel_r;

  // one line store bank per image row kept
  for (genvar g = 0; g < MAX_KERNEL; g++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] q_r;
    always_ff @(posedge clk) begin
      if (ctrl.wr && wr_bank == BANK_W'(g)) begin
        mem[addr] <= pix;
      end
      if (ctrl.wr) begin
        q_r <= mem[addr];
      end
    end
    assign rd[g] = q_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      pix_r <= pix;
    end
  end

  // slot j holds row r-j; the newest row comes from the pixel itself
  always_comb begin
    int t;
    colv[0] = pix_r;
    for (int j = 1; j < MAX_KERNEL; j++) begin
      t = int'(rd_bank) + MAX_KERNEL - j;
      if (t >= MAX_KERNEL) t = t - MAX_KERNEL;
      colv[j] = rd[BANK_W'(t)];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      for (int j = 0; j < MAX_KERNEL; j++) begin
        win_r[j][0] <= colv[j];
        for (int a = 1; a < MAX_KERNEL; a++) begin
          win_r[j][a] <= win_r[j][a-1];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_KERNEL; j++) begin
      rowsum_nxt[j] = '0;
      for (int a = 0; a < MAX_KERNEL; a++) begin
        if (a < int'(k)) rowsum_nxt[j] = rowsum_nxt[j] + ROW_W'(win_r[j][a]);
      end
    end
  end

  always_comb begin
    total_nxt = '0;
    for (int j = 0; j < MAX_KERNEL; j++) begin
      if (j < int'(k)) total_nxt = total_nxt + SUM_W'(rowsum_r[j]);
    end
  end

  // horizontal Sobel: right column minus left column, weights 1,2,1 down
  always_comb begin
    acc = $signed({3'b000, win_r[2][0]}) - $signed({3'b000, win_r[2][2]})
        + (($signed({3'b000, win_r[1][0]}) - $signed({3'b000, win_r[1][2]})) <<< 1)
        + $signed({3'b000, win_r[0][0]}) - $signed({3'b000, win_r[0][2]});
    if (acc < 0) begin
      sobel_nxt = '0;
    end else if (acc > $signed((PIX_W+3)'(PIX_MAX))) begin
      sobel_nxt = PIX_W'(PIX_MAX);
    end else begin
      sobel_nxt = acc[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum1) begin
      rowsum_r <= rowsum_nxt;
      sobel_r  <= sobel_nxt;
    end
  end

  icf_div #(.SUM_W(SUM_W), .DIV_W(DIV_W)) u_div (
    .clk      (clk),
    .load     (ctrl.sum2),
    .step     (ctrl.step),
    .dividend (total_nxt),
    .divisor  (divisor),
    .quotient (quotient)
  );

  assign result = (mode == MODE_SOBEL) ? sobel_r : quotient[PIX_W-1:0];

endmodule

FILE: rtl/icf_merge.sv
module icf_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [icf_pkg::PIX_W-1:0]   ch0,
  input  logic [icf_pkg::PIX_W-1:0]   ch1,
  input  logic [icf_pkg::PIX_W-1:0]   ch2,
  input  logic [icf_pkg::OCOL_W-1:0]  col,
  input  logic [icf_pkg::OROW_W-1:0]  row,
  input  logic                        done,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [47:0]                 out_tdata,
  output logic                        out_tlast,
  output logic                        can_load
);
  import icf_pkg::*;

  logic        valid_r;
  logic [47:0] data_r;
  logic        last_r;

  assign can_load = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {2'b00, row, col, ch2, ch1, ch0};
      last_r <= done;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

FILE: rtl/image_convolution_filter.sv
// Per pixel the FSM steps SHIFT, SUM1, FIN (gradient) or SHIFT, SUM1, SUM2, DIV, FIN
// (box); the per-lane restoring divider gives one quotient bit per cycle over SUM_W
// bits (SUM_W = 14 at MAX_KERNEL 8). Pixels without a full window give no result.
// A new pixel is taken only in IDLE; FIN waits until the output register can load.
// Reset (rst_n low, synchronous): position, row bank, FSM, output valid and
// registers to defaults; line stores and window are not cleared.
module image_convolution_filter #(
  parameter int MAX_WIDTH  = icf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_KERNEL = icf_pkg::DEF_MAX_KERNEL
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // pixel_ch0, pixel_ch1, pixel_ch2
  input  logic [0:0]                      in_tuser,   // start_of_frame
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [47:0]                     out_tdata,  // out_ch0, out_ch1, out_ch2, out_col, out_row
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [icf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [icf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import icf_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int BANK_W = $clog2(MAX_KERNEL);
  localparam int KW     = $clog2(MAX_KERNEL + 1);
  localparam int DIV_W  = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int SUM_W  = $clog2(MAX_KERNEL * MAX_KERNEL * PIX_MAX + 1);
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int WC_W   = ($clog2(MAX_WIDTH) + 1 > CFG_WID_W) ? $clog2(MAX_WIDTH) + 1 : CFG_WID_W;
  localparam int RC_W   = CFG_HGT_W + 1;

  logic [CFG_WID_W-1:0] width_r;
  logic [CFG_HGT_W-1:0] height_r;
  logic                 mode_r;
  logic [CFG_BOX_W-1:0] box_r;

  logic [COL_W-1:0]     col_r, col_nxt;
  logic [CFG_HGT_W-1:0] row_r, row_nxt;
  logic [BANK_W-1:0]    bank_r, bank_nxt;

  logic [WC_W-1:0]      w_eff;
  logic [RC_W-1:0]      h_eff;
  logic [KW-1:0]        k_eff;
  logic [WC_W-1:0]      c_a;
  logic [RC_W-1:0]      r_a;
  logic [BANK_W-1:0]    b_a;
  logic                 emit_a, done_a;

  logic [BANK_W-1:0]    bank_q;
  logic                 emit_q, done_q;
  logic [OCOL_W-1:0]    ocol_q;
  logic [OROW_W-1:0]    orow_q;
  logic [KW-1:0]        k_q;
  logic [DIV_W-1:0]     div_q;

  icf_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r;
  lane_ctrl_t           ctrl;
  logic                 accept, load_out, can_load;
  logic [PIX_W-1:0]     res [3];

  function automatic logic [BANK_W-1:0] bank_inc(input logic [BANK_W-1:0] b);
    return (b == BANK_W'(MAX_KERNEL - 1)) ? '0 : b + 1'b1;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      mode_r   <= RST_MODE;
      box_r    <= RST_BOX;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[CFG_WID_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[CFG_HGT_W-1:0];
        CFG_FILTER_MODE:  mode_r   <= cfg_data[0];
        CFG_BOX_SIZE:     box_r    <= cfg_data[CFG_BOX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = WC_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = WC_W'(MAX_WIDTH);
    end else begin
      w_eff = WC_W'(width_r);
    end
    h_eff = (height_r == '0) ? RC_W'(1) : RC_W'(height_r);
    if (mode_r == MODE_SOBEL) begin
      k_eff = KW'(SOBEL_K);
    end else if (box_r == '0) begin
      k_eff = KW'(1);
    end else if (int'(box_r) > MAX_KERNEL) begin
      k_eff = KW'(MAX_KERNEL);
    end else begin
      k_eff = KW'(box_r);
    end
  end

  // position of the incoming pixel and of the next one
  always_comb begin
    c_a = in_tuser[0] ? '0 : WC_W'(col_r);
    r_a = in_tuser[0] ? '0 : RC_W'(row_r);
    b_a = in_tuser[0] ? bank_inc(bank_r) : bank_r;
    if (c_a >= w_eff) begin
      c_a = '0;
      r_a = r_a + 1'b1;
      b_a = bank_inc(b_a);
    end
    if (r_a >= h_eff) r_a = '0;
    emit_a = (r_a + 1'b1 >= RC_W'(k_eff)) && (c_a + 1'b1 >= WC_W'(k_eff));
    done_a = (r_a == h_eff - 1'b1) && (c_a == w_eff - 1'b1);
    if (c_a + 1'b1 >= w_eff) begin
      col_nxt  = '0;
      row_nxt  = (r_a + 1'b1 >= h_eff) ? '0 : CFG_HGT_W'(r_a + 1'b1);
      bank_nxt = bank_inc(b_a);
    end else begin
      col_nxt  = COL_W'(c_a + 1'b1);
      row_nxt  = CFG_HGT_W'(r_a);
      bank_nxt = b_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      bank_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      bank_r <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bank_q <= b_a;
      emit_q <= emit_a;
      done_q <= done_a;
      ocol_q <= OCOL_W'(c_a + 1'b1 - WC_W'(k_eff));
      orow_q <= OROW_W'(r_a + 1'b1 - RC_W'(k_eff));
      k_q    <= k_eff;
      div_q  <= DIV_W'(k_eff * k_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SUM2) begin
      cnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SHIFT;
      ST_SHIFT: state_nxt = emit_q ? ST_SUM1 : ST_IDLE;
      ST_SUM1:  state_nxt = (mode_r == MODE_SOBEL) ? ST_FIN : ST_SUM2;
      ST_SUM2:  state_nxt = ST_DIV;
      ST_DIV:   if (cnt_r == CNT_W'(SUM_W - 1)) state_nxt = ST_FIN;
      ST_FIN:   if (can_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    ctrl       = '0;
    load_out   = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready  = 1'b1;
      ST_SHIFT: ctrl.shift = 1'b1;
      ST_SUM1:  ctrl.sum1  = 1'b1;
      ST_SUM2:  ctrl.sum2  = 1'b1;
      ST_DIV:   ctrl.step  = 1'b1;
      ST_FIN:   load_out   = can_load;
      default: ;
    endcase
    ctrl.wr = in_tready && in_tvalid;
  end

  assign accept = ctrl.wr;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    icf_lane #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_lane (
      .clk     (clk),
      .ctrl    (ctrl),
      .addr    (c_a[COL_W-1:0]),
      .wr_bank (b_a),
      .rd_bank (bank_q),
      .pix     (in_tdata[l*PIX_W +: PIX_W]),
      .mode    (mode_r),
      .k       (k_q),
      .divisor (div_q),
      .result  (res[l])
    );
  end

  icf_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load_out),
    .ch0        (res[0]),
    .ch1        (res[1]),
    .ch2        (res[2]),
    .col        (ocol_q),
    .row        (orow_q),
    .done       (done_q),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .can_load   (can_load)
  );

endmodule

FILE: rtl/icf_checker.sv
`include "image_convolution_filter_defines.svh"

module icf_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata
);

  `ICF_ASSERT_ALWAYS(a_rst_out_idle, clk, !rst_n |=> !out_tvalid, "output valid after reset")
  `ICF_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "request dropped")
  `ICF_ASSERT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "second request taken while busy")
  `ICF_ASSERT(a_pad_zero, clk, rst_n, out_tvalid |-> out_tdata[47:46] == 2'b00, "pad bits set")

endmodule

bind image_convolution_filter icf_checker u_icf_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import icf_pkg::*;

  localparam int LINE_ROWS   = DEF_MAX_KERNEL;
  localparam int LINE_COLS   = DEF_MAX_WIDTH;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 40;

  typedef struct {
    logic [7:0]        ch0;
    logic [7:0]        ch1;
    logic [7:0]        ch2;
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic              last;
  } filt_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;   // pixel_ch0, pixel_ch1, pixel_ch2
  logic [0:0] in_tuser = '0;    // start_of_frame
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;       // out_ch0, out_ch1, out_ch2, out_col, out_row
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  image_convolution_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [23:0] line_mem [LINE_ROWS][LINE_COLS];
  logic [CFG_WID_W-1:0] p_width = RST_WIDTH;
  logic [CFG_HGT_W-1:0] p_height = RST_HEIGHT;
  logic p_mode = RST_MODE;
  logic [CFG_BOX_W-1:0] p_box = RST_BOX;
  int p_col = 0;
  int p_row = 0;

  filt_px_t filtered_q[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 0;
  int hold_off = 0;
  int rx_pause = 0;

  function automatic int lane(int r, int c, int ch);
    logic [23:0] p;
    p = line_mem[r % LINE_ROWS][c % LINE_COLS];
    return int'(p[8*ch +: 8]);
  endfunction

  function automatic void predict_pixel(logic [23:0] pix, logic sof);
    int w, h, k, r, c, r0, c0, acc;
    filt_px_t res;
    logic [7:0] v [3];
    w = (p_width == 0) ? 1 : (p_width > LINE_COLS) ? LINE_COLS : int'(p_width);
    h = (p_height == 0) ? 1 : int'(p_height);
    if (p_mode == MODE_SOBEL) k = SOBEL_K;
    else k = (p_box == 0) ? 1 : (p_box > LINE_ROWS) ? LINE_ROWS : int'(p_box);
    if (sof) begin
      p_col = 0;
      p_row = 0;
    end
    if (p_col >= w) begin
      p_col = 0;
      p_row++;
    end
    if (p_row >= h) p_row = 0;
    r = p_row;
    c = p_col;
    line_mem[r % LINE_ROWS][c % LINE_COLS] = pix;
    if (r + 1 >= k && c + 1 >= k) begin
      r0 = r + 1 - k;
      c0 = c + 1 - k;
      for (int ch = 0; ch < 3; ch++) begin
        acc = 0;
        if (p_mode == MODE_SOBEL) begin
          for (int i = 0; i < 3; i++)
            acc += ((i == 1) ? 2 : 1) * (lane(r0 + i, c0 + 2, ch) - lane(r0 + i, c0, ch));
          acc = (acc < 0) ? 0 : (acc > PIX_MAX) ? PIX_MAX : acc;
        end else begin
          for (int i = 0; i < k; i++)
            for (int j = 0; j < k; j++)
              acc += lane(r0 + i, c0 + j, ch);
          acc = acc / (k * k);
        end
        v[ch] = acc[7:0];
      end
      res.ch0 = v[0];
      res.ch1 = v[1];
      res.ch2 = v[2];
      res.col = c0[OCOL_W-1:0];
      res.row = r0[OROW_W-1:0];
      res.last = (r == h - 1 && c == w - 1);
      filtered_q.push_back(res);
    end
    p_col = c + 1;
    if (p_col >= w) begin
      p_col = 0;
      p_row = r + 1;
      if (p_row >= h) p_row = 0;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    filt_px_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      if (filtered_q.size() == 0) begin
        $error("unexpected result: tdata=%h tlast=%b", out_tdata, out_tlast);
        errors++;
      end else begin
        exp_px = filtered_q.pop_front();
        if (out_tdata[7:0] !== exp_px.ch0) begin
          $error("out_ch0 expected %0d actual %0d", exp_px.ch0, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[15:8] !== exp_px.ch1) begin
          $error("out_ch1 expected %0d actual %0d", exp_px.ch1, out_tdata[15:8]);
          errors++;
        end
        if (out_tdata[23:16] !== exp_px.ch2) begin
          $error("out_ch2 expected %0d actual %0d", exp_px.ch2, out_tdata[23:16]);
          errors++;
        end
        if (out_tdata[33:24] !== exp_px.col) begin
          $error("out_col expected %0d actual %0d", exp_px.col, out_tdata[33:24]);
          errors++;
        end
        if (out_tdata[45:34] !== exp_px.row) begin
          $error("out_row expected %0d actual %0d", exp_px.row, out_tdata[45:34]);
          errors++;
        end
        if (out_tlast !== exp_px.last) begin
          $error("frame_done expected %0d actual %0d", exp_px.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // receiver: random stall per result, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      rx_pause = no_idle ? 0 : $urandom_range(0, 6);
      out_tready <= (rx_pause == 0);
    end else if (rx_pause > 0) begin
      rx_pause--;
      out_tready <= (rx_pause == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, int val);
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  p_width = val[CFG_WID_W-1:0];
      CFG_IMAGE_HEIGHT: p_height = val[CFG_HGT_W-1:0];
      CFG_FILTER_MODE:  p_mode = val[0];
      CFG_BOX_SIZE:     p_box = val[CFG_BOX_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(int w, int h, int mode, int box);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_FILTER_MODE, mode);
    write_reg(CFG_BOX_SIZE, box);
  endtask

  task automatic send_pixel(logic [23:0] pix, logic sof);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= pix;
    in_tuser <= sof;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(pix, sof);
  endtask

  // wait for every pending result, then let a no-result request finish
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic send_frame(int npix);
    for (int i = 0; i < npix; i++)
      send_pixel(rand_pixel(), i == 0);
  endtask

  // degenerate sizes: zero width/height/box each act as one
  task automatic test_unit_image();
    setup(0, 0, 0, 0);
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'hFF00FF, 1'b1);
    send_pixel(24'h00FF00, 1'b0);
    drain();
  endtask

  // saturated width and box, box taller than the image: nothing comes out
  task automatic test_window_too_large();
    setup(2047, 2, 0, 15);
    for (int i = 0; i < 4; i++) send_pixel(rand_pixel(), i == 0);
    drain();
  endtask

  // gradient clamps at both ends, then wrap to the next frame without a mark
  task automatic test_sobel_clamp();
    setup(3, 3, 1, 3);
    for (int i = 0; i < 9; i++)
      send_pixel((i % 3 == 0) ? 24'hFFFFFF : 24'h000000, i == 0);
    for (int i = 0; i < 9; i++)
      send_pixel((i % 3 == 2) ? 24'hFFFFFF : 24'h00FF00, 1'b0);
    drain();
  endtask

  task automatic test_random_frames();
    int sent, w, h, box, mode, npix;
    sent = 0;
    while (sent < 600) begin
      mode = $urandom_range(0, 1);
      w = $urandom_range(8, 16);
      h = $urandom_range(8, 12);
      box = $urandom_range(1, 8);
      if ($urandom_range(0, 5) == 0) box = $urandom_range(0, 1) ? 0 : 15;
      no_idle = ($urandom_range(0, 3) == 0);
      setup(w, h, mode, box);
      npix = w * h;
      case ($urandom_range(0, 5))
        0: npix = $urandom_range(1, w * h);        // cut short
        1: npix = w * h + $urandom_range(1, 3 * w); // wraps into next frame
        default: ;
      endcase
      for (int i = 0; i < npix; i++)
        send_pixel(rand_pixel(), (i == 0) || ($urandom_range(0, 199) == 0));
      sent += npix;
      drain();
    end
    no_idle = 0;
  endtask

  // widest row setting, one-pixel box so every pixel gives a result
  task automatic test_wide_rows();
    no_idle = 1;
    setup(1024, 4095, 0, 1);
    send_frame(200);
    drain();
    no_idle = 0;
  endtask

  task automatic test_output_stall();
    setup(8, 8, 0, 1);
    hold_off = 400;
    send_frame(64);
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unit_image();
    test_window_too_large();
    test_sobel_clamp();
    test_output_stall();
    test_random_frames();
    test_wide_rows();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
